// ===== design/gww_pkg.sv =====
// ---------------------------------------------------------------------------
// gww_pkg: shared types and constants for the greedy word wrap block
// Character codes, the limit ceiling, the command struct passed from the
// control sequencer to the word-holding cell chain and the sequencer's plan.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gww_pkg;

    localparam logic [7:0] CH_BLANK   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [5:0] LIMIT_CEILING     = 6'd60;
    localparam logic [5:0] MAX_COLUMNS_RESET = 6'd40;

    // Commands from the sequencer to the cell chain
    typedef struct packed {
        logic       shift;      // move every cell one place toward the head
        logic       load;       // write load_char into the cell at the tail
        logic [7:0] load_char;
    } chain_ctrl_t;

    // Work still pending for the item in progress, in emission order
    typedef struct packed {
        logic nl0;      // newline before the held text
        logic blank;    // held blank or tab
        logic word;     // held word bytes
        logic nl1;      // newline after the held text
        logic nl2;      // second newline (blank line)
        logic append;   // store the ordinary character at the end
    } plan_t;

endpackage

`default_nettype wire

// ===== design/gww_cell.sv =====
// ---------------------------------------------------------------------------
// gww_cell: one byte of the held-word chain
// Loads a new character when it is the tail position, and takes its
// neighbor's byte when the chain drains toward the head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gww_cell (
    input  wire                  aclk,
    input  wire gww_pkg::chain_ctrl_t ctrl,
    input  wire                  tail_sel,    // this cell is the next free place
    input  wire  [7:0]           next_char,   // byte of the neighbor behind
    output logic [7:0]           cell_char
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Drain takes priority; load only writes the tail cell
    always_comb begin
        data_next = data_reg;
        if (ctrl.shift) begin
            data_next = next_char;
        end else if (ctrl.load && tail_sel) begin
            data_next = ctrl.load_char;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_char = data_reg;

endmodule

`default_nettype wire

// ===== design/gww_ctrl.sv =====
// ---------------------------------------------------------------------------
// gww_ctrl: line state and output sequencer for greedy word wrap
// Decides per input byte what has to go out, then emits one byte a cycle
// while the output register is free, draining the cell chain for held words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gww_ctrl #(
    parameter int WORD_STORE_DEPTH = 64
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_we,
    input  wire  [5:0]                   cfg_wdata,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [7:0]                   s_char,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [7:0]                   m_char,
    output logic                         m_last,
    input  wire  [7:0]                   head_char,
    output gww_pkg::chain_ctrl_t         chain_ctrl,
    output logic [$clog2(WORD_STORE_DEPTH+1)-1:0] word_len
);

    localparam int WL_W = $clog2(WORD_STORE_DEPTH + 1);
    localparam logic [6:0] DEPTH_LIM = 7'(WORD_STORE_DEPTH);

    logic [5:0]      max_columns_reg;
    logic [5:0]      col_reg, col_next;
    logic            bh_reg, bh_next;
    logic [7:0]      held_reg, held_next;
    logic [WL_W-1:0] wl_reg, wl_next;
    logic            busy_reg, busy_next;
    gww_pkg::plan_t  plan_reg, plan_next;
    logic [7:0]      pend_blank_reg, pend_blank_next;
    logic [7:0]      char_reg, char_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_char_reg, m_char_next;
    logic            m_last_reg, m_last_next;

    logic [6:0] lim;
    logic [5:0] lim_sat;
    logic       s_accept;
    logic       out_free;
    logic       emit_any;

    // Saturate the limit to 1..60 and to the store depth
    always_comb begin
        if (max_columns_reg == 6'd0) begin
            lim_sat = 6'd1;
        end else if (max_columns_reg > gww_pkg::LIMIT_CEILING) begin
            lim_sat = gww_pkg::LIMIT_CEILING;
        end else begin
            lim_sat = max_columns_reg;
        end
        lim = ({1'b0, lim_sat} > DEPTH_LIM) ? DEPTH_LIM : {1'b0, lim_sat};
    end

    assign s_ready  = !busy_reg;
    assign s_accept = s_valid && !busy_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign emit_any = plan_reg.nl0 || plan_reg.blank || plan_reg.word ||
                      plan_reg.nl1 || plan_reg.nl2;

    // Plan the item on accept, then emit one byte per free output slot
    always_comb begin
        logic [6:0] sum;
        logic       is_blank;
        logic       rem;

        col_next        = col_reg;
        bh_next         = bh_reg;
        held_next       = held_reg;
        wl_next         = wl_reg;
        busy_next       = busy_reg;
        plan_next       = plan_reg;
        pend_blank_next = pend_blank_reg;
        char_next       = char_reg;
        m_valid_next    = m_valid_reg;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        chain_ctrl      = '0;
        sum      = {1'b0, col_reg} + 7'(bh_reg) + 7'(wl_reg);
        is_blank = (s_char == gww_pkg::CH_BLANK) || (s_char == gww_pkg::CH_TAB);
        rem      = 1'b0;

        // Drop the shown byte once the receiver takes it
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_accept) begin
            busy_next       = 1'b1;
            plan_next       = '0;
            pend_blank_next = held_reg;
            char_next       = s_char;
            if (s_char == gww_pkg::CH_NEWLINE) begin
                plan_next.blank = bh_reg;
                plan_next.word  = (wl_reg != '0);
                plan_next.nl1   = 1'b1;
                plan_next.nl2   = 1'b1;
                col_next        = 6'd0;
                bh_next         = 1'b0;
            end else if (is_blank) begin
                plan_next.blank = bh_reg;
                plan_next.word  = (wl_reg != '0);
                if (sum + 7'd1 > lim) begin
                    plan_next.nl1 = 1'b1;
                    col_next      = 6'd0;
                    bh_next       = 1'b0;
                end else begin
                    col_next  = sum[5:0];
                    bh_next   = 1'b1;
                    held_next = s_char;
                end
            end else begin
                plan_next.append = 1'b1;
                if (sum + 7'd1 > lim) begin
                    plan_next.nl0 = bh_reg || (col_reg != 6'd0);
                    col_next      = 6'd0;
                    bh_next       = 1'b0;
                    if (7'(wl_reg) + 7'd1 > lim) begin
                        plan_next.word = (wl_reg != '0);
                        plan_next.nl1  = 1'b1;
                    end
                end
            end
        end else if (busy_reg) begin
            if (emit_any) begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (plan_reg.nl0) begin
                        m_char_next   = gww_pkg::CH_NEWLINE;
                        plan_next.nl0 = 1'b0;
                    end else if (plan_reg.blank) begin
                        m_char_next     = pend_blank_reg;
                        plan_next.blank = 1'b0;
                    end else if (plan_reg.word) begin
                        m_char_next      = head_char;
                        chain_ctrl.shift = 1'b1;
                        wl_next          = wl_reg - WL_W'(1);
                        plan_next.word   = (wl_reg != WL_W'(1));
                    end else if (plan_reg.nl1) begin
                        m_char_next   = gww_pkg::CH_NEWLINE;
                        plan_next.nl1 = 1'b0;
                    end else begin
                        m_char_next   = gww_pkg::CH_NEWLINE;
                        plan_next.nl2 = 1'b0;
                    end
                    rem = plan_next.nl0 || plan_next.blank || plan_next.word ||
                          plan_next.nl1 || plan_next.nl2;
                    m_last_next = !rem;
                end
            end else begin
                // All bytes out: store the ordinary character, if any, and finish
                if (plan_reg.append) begin
                    chain_ctrl.load      = 1'b1;
                    chain_ctrl.load_char = char_reg;
                    wl_next              = wl_reg + WL_W'(1);
                end
                plan_next.append = 1'b0;
                busy_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_columns_reg <= gww_pkg::MAX_COLUMNS_RESET;
            col_reg         <= 6'd0;
            bh_reg          <= 1'b0;
            held_reg        <= 8'd0;
            wl_reg          <= '0;
            busy_reg        <= 1'b0;
            plan_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_columns_reg <= cfg_wdata;
            end
            col_reg     <= col_next;
            bh_reg      <= bh_next;
            held_reg    <= held_next;
            wl_reg      <= wl_next;
            busy_reg    <= busy_next;
            plan_reg    <= plan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_blank_reg <= pend_blank_next;
        char_reg       <= char_next;
        m_char_reg     <= m_char_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_char   = m_char_reg;
    assign m_last   = m_last_reg;
    assign word_len = wl_reg;

endmodule

`default_nettype wire

// ===== design/greedy_word_wrap.sv =====
// ---------------------------------------------------------------------------
// greedy_word_wrap: greedy word wrap on a byte stream
// Holds the current word in a chain of byte cells and sends wrapped text.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one input byte per transfer; m_* carries output bytes, with
//   m_tlast high on the final byte caused by one input byte. An input byte
//   that is only held back produces no output transfer.
//   cfg_we/cfg_wdata write max_columns (reset 40); write only while idle.
// Flow:
//   s_tready drops for the whole item after a transfer. The first output
//   byte is planned into the plan register and then shown in the output
//   register; one byte follows per cycle while m_tready stays high. An item
//   sends N output bytes (N up to the limit plus two) through the single
//   output register, draining the word cell chain one byte per free slot.
// Reset:
//   aresetn (synchronous, active low) empties the held text, clears the
//   column count and restores max_columns to 40.
// Stall:
//   While m_tready is low the shown byte holds and the drain pauses; no
//   byte is lost or repeated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_word_wrap #(
    parameter int WORD_STORE_DEPTH = 64
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_we,
    input  wire  [5:0] cfg_wdata,   // max_columns
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,     // [7:0] in_char
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_char
    output logic       m_tlast      // last_of_run
);

    localparam int WL_W = $clog2(WORD_STORE_DEPTH + 1);

    gww_pkg::chain_ctrl_t chain_ctrl;
    logic [WL_W-1:0]      word_len;
    logic [7:0]           cell_char [WORD_STORE_DEPTH];

    gww_ctrl #(
        .WORD_STORE_DEPTH (WORD_STORE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_char     (s_tdata),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_char     (m_tdata),
        .m_last     (m_tlast),
        .head_char  (cell_char[0]),
        .chain_ctrl (chain_ctrl),
        .word_len   (word_len)
    );

    // Word chain: head at cell 0, drains toward the head
    for (genvar i = 0; i < WORD_STORE_DEPTH; i++) begin : g_cell
        logic [7:0] next_char;
        if (i == WORD_STORE_DEPTH - 1) begin : g_tail
            assign next_char = 8'h00;
        end else begin : g_mid
            assign next_char = cell_char[i+1];
        end

        gww_cell u_cell (
            .aclk      (aclk),
            .ctrl      (chain_ctrl),
            .tail_sel  (word_len == WL_W'(i)),
            .next_char (next_char),
            .cell_char (cell_char[i])
        );
    end

endmodule

`default_nettype wire
